// ===== rtl/chr420_pkg.sv =====
package chr420_pkg;

   // Frame geometry limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 12;
   localparam int SAMPLE_W   = 8;
   localparam int PAIR_W     = SAMPLE_W + 1;
   localparam int QUAD_W     = SAMPLE_W + 2;

   localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] WIDTH_RESET    = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET   = 12'd480;

   // Register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pixel_u;
      logic [SAMPLE_W-1:0] pixel_v;
   } pixel_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] block_u;
      logic [SAMPLE_W-1:0] block_v;
      logic [9:0]          block_col;
      logic [9:0]          block_row;
      logic                last_block;
   } block_type;

   // One line store entry: horizontal pair sums of the even row
   typedef struct packed {
      logic [PAIR_W-1:0] sum_u;
      logic [PAIR_W-1:0] sum_v;
   } line_entry_type;

   // Decoded step for the pixel at the current position
   typedef struct packed {
      logic                emit;
      logic                mem_write;
      logic                mem_read;
      logic [LINE_AW-1:0]  line_addr;
      logic [PAIR_W-1:0]   sum_u;
      logic [PAIR_W-1:0]   sum_v;
      logic [9:0]          block_col;
      logic [9:0]          block_row;
      logic                last_block;
   } pos_info_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > max_v) begin
         r = max_v;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/chroma_420_subsampler_unit.sv =====
// 4:2:0 chroma subsampler: takes the U and V samples of 4:4:4 pixels in raster
// order and returns one truncated 2x2 average per block, tagged with block column,
// block row and a last-block mark; an odd last column or row counts twice. The
// unit accepts one pixel per clock while req_ready is high: the line store has one
// read and one write port, and each pixel touches at most one entry. A result passes
// through the combine stage and the output register on its way to rsp_valid. A stalled
// result side holds up to two blocks (combine stage and output register) before req_ready
// drops. A write to frame_width or frame_height restarts the frame at row 0,
// column 0; write them only while idle. The line store needs no clearing after reset.
module chroma_420_subsampler_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  chr420_pkg::pixel_type          req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output chr420_pkg::block_type          rsp_payload,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [chr420_pkg::DIM_W-1:0]   csr_wdata
);
   import chr420_pkg::*;

   pos_info_type    info;
   logic            accept;
   line_entry_type  wr_entry;
   line_entry_type  rd_entry;
   logic            mem_wr_en;
   logic            mem_rd_en;

   // Combine stage, waiting on the line store read
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_use_mem_ff;
   logic [PAIR_W-1:0]  s1_sum_u_ff;
   logic [PAIR_W-1:0]  s1_sum_v_ff;
   logic [9:0]         s1_col_ff;
   logic [9:0]         s1_row_ff;
   logic               s1_last_ff;
   logic               s1_go;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   block_type          rsp_data_ff;
   logic [QUAD_W-1:0]  quad_u;
   logic [QUAD_W-1:0]  quad_v;

   assign accept = req_valid && req_ready;

   chr420_pos u_pos (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .pixel        (req_payload),
      .info         (info)
   );

   // Even rows store pair sums, odd rows read them back
   assign mem_wr_en      = accept && info.mem_write;
   assign mem_rd_en      = accept && info.mem_read;
   assign wr_entry.sum_u = info.sum_u;
   assign wr_entry.sum_v = info.sum_v;

   chr420_line_mem u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (info.line_addr),
      .wr_data (wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (info.line_addr),
      .rd_data (rd_entry)
   );

   // Handshake: advance the combine stage when the output register frees up
   always_comb begin
      s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || s1_go;
      s1_valid_in  = (s1_valid_ff && !s1_go) || (accept && info.emit);
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || s1_go;
   end

   // Vertical sum: stored pair plus this pair, or a lone last row doubled
   always_comb begin
      if (s1_use_mem_ff) begin
         quad_u = QUAD_W'(rd_entry.sum_u) + QUAD_W'(s1_sum_u_ff);
         quad_v = QUAD_W'(rd_entry.sum_v) + QUAD_W'(s1_sum_v_ff);
      end else begin
         quad_u = {s1_sum_u_ff, 1'b0};
         quad_v = {s1_sum_v_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the combine stage on an emitting transfer
   always_ff @(posedge clock) begin
      if (accept && info.emit) begin
         s1_use_mem_ff <= info.mem_read;
         s1_sum_u_ff   <= info.sum_u;
         s1_sum_v_ff   <= info.sum_v;
         s1_col_ff     <= info.block_col;
         s1_row_ff     <= info.block_row;
         s1_last_ff    <= info.last_block;
      end
   end

   // Divide by four and hold the result until its transfer
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff.block_u    <= quad_u[QUAD_W-1:2];
         rsp_data_ff.block_v    <= quad_v[QUAD_W-1:2];
         rsp_data_ff.block_col  <= s1_col_ff;
         rsp_data_ff.block_row  <= s1_row_ff;
         rsp_data_ff.last_block <= s1_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The line store never reads and writes in the same step
   a_no_rw_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("line store read and write in one cycle");

   // An emitting transfer never lands on an occupied, stalled combine stage
   a_no_s1_overrun: assert property (@(posedge clock) disable iff (reset)
      !(accept && info.emit && s1_valid_ff && !s1_go))
      else $error("combine stage overrun");

   // A stalled combine stage keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("combine stage lost its item");

   // A stalled combine stage that uses the line store keeps its read data
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_use_mem_ff && !s1_go |=> $stable(rd_entry))
      else $error("line store read data changed under a stall");

endmodule

// ===== rtl/chr420_line_mem.sv =====
module chr420_line_mem (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [chr420_pkg::LINE_AW-1:0]    wr_addr,
   input  chr420_pkg::line_entry_type        wr_data,
   input  logic                              rd_en,
   input  logic [chr420_pkg::LINE_AW-1:0]    rd_addr,
   output chr420_pkg::line_entry_type        rd_data
);
   import chr420_pkg::*;

   line_entry_type mem_ff [LINE_DEPTH];
   line_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/chr420_pos.sv =====
module chr420_pos (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [chr420_pkg::DIM_W-1:0]   csr_wdata,
   input  logic                           accept,
   input  chr420_pkg::pixel_type          pixel,
   output chr420_pkg::pos_info_type       info
);
   import chr420_pkg::*;

   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [SAMPLE_W-1:0] held_u_ff, held_u_in;
   logic [SAMPLE_W-1:0] held_v_ff, held_v_in;

   logic [DIM_W-1:0]    width_eff;
   logic [DIM_W-1:0]    height_eff;
   logic                last_col;
   logic                last_row;
   logic                even_col;
   logic                odd_row;
   logic                pair_ready;
   logic [PAIR_W-1:0]   pair_u;
   logic [PAIR_W-1:0]   pair_v;

   // Decode the current position
   always_comb begin
      width_eff  = clamp_dim(width_ff, MAX_WIDTH_DIM);
      height_eff = clamp_dim(height_ff, MAX_HEIGHT_DIM);
      last_col   = (DIM_W'(col_ff) + DIM_W'(1)) >= width_eff;
      last_row   = (DIM_W'(row_ff) + DIM_W'(1)) >= height_eff;
      even_col   = !col_ff[0];
      odd_row    = row_ff[0];
      pair_ready = !even_col || last_col;

      // Form the horizontal pair, doubling a lone last column
      if (even_col) begin
         pair_u = {pixel.pixel_u, 1'b0};
         pair_v = {pixel.pixel_v, 1'b0};
      end else begin
         pair_u = PAIR_W'(held_u_ff) + PAIR_W'(pixel.pixel_u);
         pair_v = PAIR_W'(held_v_ff) + PAIR_W'(pixel.pixel_v);
      end

      info.emit       = pair_ready && (odd_row || last_row);
      info.mem_write  = pair_ready && !odd_row && !last_row;
      info.mem_read   = pair_ready && odd_row;
      info.line_addr  = col_ff[COL_W-1:1];
      info.sum_u      = pair_u;
      info.sum_v      = pair_v;
      info.block_col  = 10'(col_ff[COL_W-1:1]);
      info.block_row  = 10'(row_ff[ROW_W-1:1]);
      info.last_block = last_col && last_row;
   end

   // Next state: registers, position and held samples
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_u_in = held_u_ff;
      held_v_in = held_v_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default:          width_in  = width_ff;
         endcase
         // restart the frame on any register write
         col_in    = '0;
         row_in    = '0;
         held_u_in = '0;
         held_v_in = '0;
      end else if (accept) begin
         if (even_col && !last_col) begin
            held_u_in = pixel.pixel_u;
            held_v_in = pixel.pixel_v;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         held_u_ff <= '0;
         held_v_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         held_u_ff <= held_u_in;
         held_v_ff <= held_v_in;
      end
   end

endmodule
